// File: rtl/trial_division_prime_test_defines.svh
// Assertion macros used by the trial division prime test RTL.
`ifndef TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define TDPT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define TDPT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tdpt_pkg.sv
// Package: constants, types and FSM encoding for the trial division prime test.
`default_nettype none

package tdpt_pkg;

	localparam int FIELD_W       = 32;
	localparam int WIDTH_DEF     = 32;
	localparam int FIRST_DIVISOR = 2;
	localparam int MIN_PRIME     = 2;

	typedef struct packed {
		logic               start;
		logic [FIELD_W-1:0] dividend;
		logic [FIELD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [FIELD_W-1:0] quotient;
		logic [FIELD_W-1:0] remainder;
	} div_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT,
		ST_DECIDE,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

// File: rtl/tdpt_in_if.sv
// Interface: input channel carrying the number to test.
`default_nettype none

interface tdpt_in_if;
	logic                         valid;
	logic                         ready;
	logic [tdpt_pkg::FIELD_W-1:0] number;

	modport source (output valid, output number, input ready);
	modport sink   (input valid, input number, output ready);
endinterface

`default_nettype wire

// File: rtl/tdpt_out_if.sv
// Interface: result channel carrying the tested value and the prime flag.
`default_nettype none

interface tdpt_out_if;
	logic                         valid;
	logic                         ready;
	logic [tdpt_pkg::FIELD_W-1:0] tested_value;
	logic                         is_prime;

	modport source (output valid, output tested_value, output is_prime, input ready);
	modport sink   (input valid, input tested_value, input is_prime, output ready);
endinterface

`default_nettype wire

// File: rtl/tdpt_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module tdpt_divider #(
	parameter int NW = tdpt_pkg::FIELD_W
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tdpt_pkg::div_req_t req,
	output      tdpt_pkg::div_rsp_t rsp
);
	import tdpt_pkg::*;

	localparam int CNT_W = $clog2(NW);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] count_q;
	logic [NW-1:0]    quo_q;
	logic [NW-1:0]    rem_q;
	logic [NW-1:0]    divisor_q;

	logic [NW:0]      trial;
	logic [NW:0]      diff;
	logic             take;
	logic [NW-1:0]    next_rem;

	assign trial    = {rem_q, quo_q[NW-1]};
	assign diff     = trial - {1'b0, divisor_q};
	assign take     = ~diff[NW];
	assign next_rem = take ? diff[NW-1:0] : trial[NW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				count_q <= '0;
			end else if (busy_q) begin
				count_q <= count_q + CNT_W'(1);
				if (count_q == CNT_W'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q     <= req.dividend[NW-1:0];
			rem_q     <= '0;
			divisor_q <= req.divisor[NW-1:0];
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], take};
			rem_q <= next_rem;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = FIELD_W'(quo_q);
	assign rsp.remainder = FIELD_W'(rem_q);

endmodule

`default_nettype wire

// File: rtl/trial_division_prime_test.sv
// Top level: trial division primality test with a shared bit-serial divider.
//
// Usage
//   query   : input channel, valid/ready, carries number. A transfer takes
//             place when valid and ready are both high at a rising edge.
//   verdict : result channel, valid/ready, carries tested_value (number cut
//             to its low WIDTH bits, at most 32) and is_prime.
//   One result per input. Zero and one are reported not prime.
//   Divisors d = 2, 3, ... are tried while d <= n / d; each divisor runs the
//   divider over all NW quotient bits (NW = min(WIDTH, 32)) and passes
//   through ST_START, ST_WAIT and ST_DECIDE. For n below two the FSM goes
//   from ST_IDLE straight to ST_FINISH; otherwise up to roughly 2^(NW/2)
//   divisors are tried for a prime. The divider sets the rate.
//   query.ready is high only while no item is in progress; one item at a time.
//   The result sits in an output register; a new item is taken while it
//   waits, and the next result is held back until verdict.ready frees it.
//   Asynchronous reset (arst_n low) drops any item in progress and any
//   pending result.
`default_nettype none
`include "trial_division_prime_test_defines.svh"

module trial_division_prime_test #(
	parameter int WIDTH = tdpt_pkg::WIDTH_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	tdpt_in_if.sink     query,
	tdpt_out_if.source  verdict
);
	import tdpt_pkg::*;

	localparam int NW = (WIDTH < FIELD_W) ? WIDTH : FIELD_W;

	state_t              state_q;
	state_t              state_d;
	logic                out_valid_q;
	logic [NW-1:0]       n_q;
	logic [NW-1:0]       d_q;
	logic                prime_q;
	logic [FIELD_W-1:0]  tested_value_q;
	logic                is_prime_q;

	logic                accept;
	logic                load_out;
	logic                in_ready;
	logic                small_n;
	logic                past_bound;
	logic                divides;

	div_req_t            div_req;
	div_rsp_t            div_rsp;

	tdpt_divider #(
		.NW (NW)
	) u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign accept     = query.valid && in_ready;
	assign small_n    = query.number[NW-1:0] < NW'(MIN_PRIME);
	assign past_bound = d_q > div_rsp.quotient[NW-1:0];
	assign divides    = div_rsp.remainder[NW-1:0] == '0;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = small_n ? ST_FINISH : ST_START;
				end
			end
			ST_START: begin
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (past_bound || divides) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_START;
				end
			end
			ST_FINISH: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready         = 1'b0;
		load_out         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = FIELD_W'(n_q);
		div_req.divisor  = FIELD_W'(d_q);
		unique case (state_q)
			ST_IDLE:   in_ready      = 1'b1;
			ST_START:  div_req.start = 1'b1;
			ST_WAIT:   ;
			ST_DECIDE: ;
			ST_FINISH: load_out      = !out_valid_q || verdict.ready;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (verdict.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					n_q     <= query.number[NW-1:0];
					d_q     <= NW'(FIRST_DIVISOR);
					prime_q <= 1'b0;
				end
			end
			ST_DECIDE: begin
				if (past_bound) begin
					prime_q <= 1'b1;
				end else if (divides) begin
					prime_q <= 1'b0;
				end else begin
					d_q <= d_q + NW'(1);
				end
			end
			ST_START, ST_WAIT, ST_FINISH: ;
			default: ;
		endcase
		if (load_out) begin
			tested_value_q <= FIELD_W'(n_q);
			is_prime_q     <= prime_q;
		end
	end

	assign query.ready          = in_ready;
	assign verdict.valid        = out_valid_q;
	assign verdict.tested_value = tested_value_q;
	assign verdict.is_prime     = is_prime_q;

	`TDPT_ASSERT_IMP(a_done_in_wait, div_rsp.done, state_q == ST_WAIT,
		"divider finished outside the wait state")
	`TDPT_ASSERT_IMP(a_divisor_floor, state_q == ST_DECIDE, d_q >= NW'(FIRST_DIVISOR),
		"trial divisor below two")
	`TDPT_ASSERT_NXT(a_bound_prime, (state_q == ST_DECIDE) && past_bound,
		(state_q == ST_FINISH) && prime_q, "square bound passed without prime verdict")
	`TDPT_ASSERT_IMP(a_prime_floor, verdict.valid && verdict.is_prime,
		verdict.tested_value >= FIELD_W'(MIN_PRIME), "value below two flagged prime")

endmodule

`default_nettype wire
